// File: rtl/sorted_value_table_core_assert.svh
// ----------------------------------------------------------------------------
// Sorted value table assertion macros
// Shared concurrent assertion forms, clocked on clk and held off in reset.
// ----------------------------------------------------------------------------
`ifndef SORTED_VALUE_TABLE_CORE_ASSERT_SVH
`define SORTED_VALUE_TABLE_CORE_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent
`define SVT_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sorted value table check failed");

// Consequent must hold in the cycle after the antecedent
`define SVT_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sorted value table check failed");

`endif

// File: rtl/svt_pkg.sv
// ----------------------------------------------------------------------------
// Sorted value table package
// Sizes, item types, command and status codes shared by the table modules.
// ----------------------------------------------------------------------------
package svt_pkg;

    localparam int CAPACITY   = 32;
    localparam int DATA_WIDTH = 32;
    localparam int IDX_W      = $clog2(CAPACITY);
    localparam int CNT_W      = $clog2(CAPACITY + 1);

    typedef logic signed [DATA_WIDTH-1:0] data_t;

    // Command codes
    localparam logic [3:0] FN_CLEAR     = 4'd0;
    localparam logic [3:0] FN_APPEND    = 4'd1;
    localparam logic [3:0] FN_SORT_ASC  = 4'd2;
    localparam logic [3:0] FN_SORT_DESC = 4'd3;
    localparam logic [3:0] FN_INSERT    = 4'd4;
    localparam logic [3:0] FN_DELETE    = 4'd5;
    localparam logic [3:0] FN_SEARCH    = 4'd6;
    localparam logic [3:0] FN_DUMP_FWD  = 4'd7;
    localparam logic [3:0] FN_DUMP_REV  = 4'd8;

    // Status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_EMPTY    = 2'd1;
    localparam logic [1:0] ST_FULL     = 2'd2;
    localparam logic [1:0] ST_NOTFOUND = 2'd3;

    typedef struct packed {
        logic [3:0]         func;
        logic signed [31:0] value;
    } in_item_t;

    typedef struct packed {
        logic signed [31:0] item_value;
        logic [5:0]         position;
        logic [5:0]         match_count;
        logic [1:0]         status;
        logic               last;
    } out_item_t;

    typedef enum logic [2:0] {
        OP_HOLD,
        OP_APPEND,
        OP_SORT,
        OP_INSERT,
        OP_DELETE,
        OP_ROT_FWD,
        OP_ROT_BWD
    } cell_op_t;

    typedef struct packed {
        cell_op_t          op;
        data_t             operand;
        logic [CNT_W-1:0]  count;
        logic              parity;
        logic              descending;
        logic              any_match;
    } cell_ctrl_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SORT,
        S_INSERT,
        S_DEL_CMP,
        S_DEL_APPLY,
        S_WALK,
        S_RWALK_PRE,
        S_RWALK,
        S_EMIT
    } state_t;

endpackage

// File: rtl/sorted_value_table_core.sv
// Sort, insert and delete sort the N entries (one odd-even compare-exchange
// phase per cycle, N phases per sort); insert adds an insert step, delete a
// compare and an apply step. Dumps give one result per cycle unless stalled;
// a search walks the N entries and then adds the count. One item at a time:
// the next is taken once the last result is registered.
// Reset clears the length, the sequencer and the output valid only.
// ----------------------------------------------------------------------------
// Sorted value table core
// List of signed values, sorted on command, kept in a row of cells with a sequencer.
// ----------------------------------------------------------------------------
module sorted_value_table_core (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  svt_pkg::in_item_t  in_item,
    output logic               out_valid,
    input  logic               out_stall,
    output svt_pkg::out_item_t out_item
);

    svt_pkg::state_t               state_reg, state_next;
    logic [svt_pkg::CNT_W-1:0]     count_reg, count_next;
    logic [svt_pkg::CNT_W-1:0]     step_reg, step_next;
    logic [svt_pkg::CNT_W-1:0]     occ_reg, occ_next;
    logic [svt_pkg::CNT_W-1:0]     res_count_reg, res_count_next;
    logic [1:0]                    res_status_reg, res_status_next;
    logic [3:0]                    func_reg, func_next;
    svt_pkg::data_t                operand_reg, operand_next;
    logic                          desc_reg, desc_next;
    logic [svt_pkg::CAPACITY-1:0]  match_reg, match_next;
    logic                          out_valid_reg, out_valid_next;
    svt_pkg::out_item_t            out_item_reg, out_item_next;

    svt_pkg::cell_ctrl_t           ctrl;
    svt_pkg::cell_op_t             op;
    svt_pkg::data_t                cell_value [svt_pkg::CAPACITY];
    logic [svt_pkg::CAPACITY-1:0]  cell_lt;
    logic [svt_pkg::CAPACITY-1:0]  cell_eq;
    logic [svt_pkg::CAPACITY-1:0]  cell_swap;
    logic [svt_pkg::CAPACITY-1:0]  cell_live;
    svt_pkg::data_t                wrap_value;
    logic [svt_pkg::IDX_W-1:0]     tail_idx;
    logic                          out_free;
    logic                          emit;
    svt_pkg::out_item_t            emit_item;
    logic                          walk_last;

    assign out_free  = !out_valid_reg || !out_stall;
    assign in_stall  = (state_reg != svt_pkg::S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;
    assign walk_last = (step_reg + svt_pkg::CNT_W'(1)) == count_reg;

    // Drive the shared cell controls
    assign tail_idx   = svt_pkg::IDX_W'(count_reg - svt_pkg::CNT_W'(1));
    assign wrap_value = (op == svt_pkg::OP_ROT_BWD) ? cell_value[tail_idx] : cell_value[0];
    always_comb
    begin
        ctrl.op         = op;
        ctrl.operand    = (state_reg == svt_pkg::S_IDLE) ? in_item.value : operand_reg;
        ctrl.count      = count_reg;
        ctrl.parity     = step_reg[0];
        ctrl.descending = desc_reg;
        ctrl.any_match  = |match_reg;
    end

    // Build the row of cells
    genvar gi;
    generate
        for (gi = 0; gi < svt_pkg::CAPACITY; gi++)
        begin : g_cell
            svt_pkg::data_t left_v;
            svt_pkg::data_t right_v;
            logic           left_l;
            logic           left_s;
            if (gi == 0)
            begin : g_head
                assign left_v = '0;
                assign left_l = 1'b1;
                assign left_s = 1'b0;
            end
            else
            begin : g_body
                assign left_v = cell_value[gi-1];
                assign left_l = cell_lt[gi-1];
                assign left_s = cell_swap[gi-1];
            end
            if (gi == svt_pkg::CAPACITY - 1)
            begin : g_end
                assign right_v = '0;
            end
            else
            begin : g_mid
                assign right_v = cell_value[gi+1];
            end
            assign cell_live[gi] = svt_pkg::CNT_W'(gi) < count_reg;

            svt_cell u_cell (
                .clk         (clk),
                .ctrl        (ctrl),
                .index       (svt_pkg::IDX_W'(gi)),
                .left_value  (left_v),
                .right_value (right_v),
                .wrap_value  (wrap_value),
                .left_lt     (left_l),
                .left_swap   (left_s),
                .value       (cell_value[gi]),
                .lt          (cell_lt[gi]),
                .eq          (cell_eq[gi]),
                .swap        (cell_swap[gi])
            );
        end
    endgenerate

    // Sequence commands and pick results
    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        step_next       = step_reg;
        occ_next        = occ_reg;
        res_count_next  = res_count_reg;
        res_status_next = res_status_reg;
        func_next       = func_reg;
        operand_next    = operand_reg;
        desc_next       = desc_reg;
        match_next      = match_reg;
        op              = svt_pkg::OP_HOLD;
        emit            = 1'b0;
        emit_item       = '0;

        unique case (state_reg)
            svt_pkg::S_IDLE:
            begin
                if (in_valid)
                begin
                    func_next       = in_item.func;
                    operand_next    = in_item.value;
                    step_next       = '0;
                    occ_next        = '0;
                    res_count_next  = '0;
                    res_status_next = svt_pkg::ST_OK;
                    state_next      = svt_pkg::S_EMIT;
                    unique case (in_item.func)
                        svt_pkg::FN_CLEAR:
                        begin
                            count_next = '0;
                        end
                        svt_pkg::FN_APPEND:
                        begin
                            if (in_item.value != '0)
                            begin
                                if (count_reg >= svt_pkg::CNT_W'(svt_pkg::CAPACITY))
                                    res_status_next = svt_pkg::ST_FULL;
                                else
                                begin
                                    op         = svt_pkg::OP_APPEND;
                                    count_next = count_reg + svt_pkg::CNT_W'(1);
                                end
                            end
                        end
                        svt_pkg::FN_SORT_ASC, svt_pkg::FN_SORT_DESC,
                        svt_pkg::FN_INSERT, svt_pkg::FN_DELETE:
                        begin
                            if (count_reg == '0)
                                res_status_next = svt_pkg::ST_EMPTY;
                            else
                            begin
                                desc_next  = (in_item.func == svt_pkg::FN_SORT_DESC);
                                state_next = svt_pkg::S_SORT;
                            end
                        end
                        svt_pkg::FN_SEARCH, svt_pkg::FN_DUMP_FWD:
                        begin
                            if (count_reg == '0)
                                res_status_next = svt_pkg::ST_EMPTY;
                            else
                                state_next = svt_pkg::S_WALK;
                        end
                        svt_pkg::FN_DUMP_REV:
                        begin
                            if (count_reg == '0)
                                res_status_next = svt_pkg::ST_EMPTY;
                            else
                                state_next = svt_pkg::S_RWALK_PRE;
                        end
                        default:
                        begin
                            res_status_next = svt_pkg::ST_OK;
                        end
                    endcase
                end
            end
            svt_pkg::S_SORT:
            begin
                op        = svt_pkg::OP_SORT;
                step_next = step_reg + svt_pkg::CNT_W'(1);
                if (walk_last)
                begin
                    step_next  = '0;
                    state_next = svt_pkg::S_EMIT;
                    if (func_reg == svt_pkg::FN_INSERT)
                    begin
                        if (count_reg >= svt_pkg::CNT_W'(svt_pkg::CAPACITY))
                            res_status_next = svt_pkg::ST_FULL;
                        else
                            state_next = svt_pkg::S_INSERT;
                    end
                    else if (func_reg == svt_pkg::FN_DELETE)
                        state_next = svt_pkg::S_DEL_CMP;
                end
            end
            svt_pkg::S_INSERT:
            begin
                op         = svt_pkg::OP_INSERT;
                count_next = count_reg + svt_pkg::CNT_W'(1);
                state_next = svt_pkg::S_EMIT;
            end
            svt_pkg::S_DEL_CMP:
            begin
                match_next = cell_eq & cell_live;
                state_next = svt_pkg::S_DEL_APPLY;
            end
            svt_pkg::S_DEL_APPLY:
            begin
                state_next = svt_pkg::S_EMIT;
                if (|match_reg)
                begin
                    op         = svt_pkg::OP_DELETE;
                    count_next = count_reg - svt_pkg::CNT_W'(1);
                end
                else
                    res_status_next = svt_pkg::ST_NOTFOUND;
            end
            svt_pkg::S_WALK:
            begin
                if (out_free)
                begin
                    op        = svt_pkg::OP_ROT_FWD;
                    step_next = step_reg + svt_pkg::CNT_W'(1);
                    emit_item.item_value = cell_value[0];
                    emit_item.position   = step_reg + svt_pkg::CNT_W'(1);
                    emit_item.status     = svt_pkg::ST_OK;
                    if (func_reg == svt_pkg::FN_SEARCH)
                    begin
                        emit = cell_eq[0];
                        if (cell_eq[0])
                            occ_next = occ_reg + svt_pkg::CNT_W'(1);
                        if (walk_last)
                        begin
                            res_count_next  = occ_next;
                            res_status_next = (occ_next != '0) ? svt_pkg::ST_OK
                                                               : svt_pkg::ST_NOTFOUND;
                            state_next      = svt_pkg::S_EMIT;
                        end
                    end
                    else
                    begin
                        emit           = 1'b1;
                        emit_item.last = walk_last;
                        if (walk_last)
                            state_next = svt_pkg::S_IDLE;
                    end
                end
            end
            svt_pkg::S_RWALK_PRE:
            begin
                op         = svt_pkg::OP_ROT_BWD;
                state_next = svt_pkg::S_RWALK;
            end
            svt_pkg::S_RWALK:
            begin
                if (out_free)
                begin
                    emit                 = 1'b1;
                    emit_item.item_value = cell_value[0];
                    emit_item.position   = count_reg - step_reg;
                    emit_item.status     = svt_pkg::ST_OK;
                    emit_item.last       = walk_last;
                    step_next            = step_reg + svt_pkg::CNT_W'(1);
                    if (walk_last)
                        state_next = svt_pkg::S_IDLE;
                    else
                        op = svt_pkg::OP_ROT_BWD;
                end
            end
            svt_pkg::S_EMIT:
            begin
                if (out_free)
                begin
                    emit                  = 1'b1;
                    emit_item.match_count = res_count_reg;
                    emit_item.status      = res_status_reg;
                    emit_item.last        = 1'b1;
                    state_next            = svt_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = svt_pkg::S_IDLE;
            end
        endcase
    end

    // Load the output register when it is free
    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_item_next  = out_item_reg;
        if (out_free)
        begin
            out_valid_next = emit;
            if (emit)
                out_item_next = emit_item;
        end
    end

    // Hold control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= svt_pkg::S_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Hold working values
    always_ff @(posedge clk)
    begin
        step_reg       <= step_next;
        occ_reg        <= occ_next;
        res_count_reg  <= res_count_next;
        res_status_reg <= res_status_next;
        func_reg       <= func_next;
        operand_reg    <= operand_next;
        desc_reg       <= desc_next;
        match_reg      <= match_next;
        out_item_reg   <= out_item_next;
    end

endmodule

// File: rtl/svt_cell.sv
// ----------------------------------------------------------------------------
// Sorted value table cell
// Holds one list entry and trades values with its two neighbors.
// ----------------------------------------------------------------------------
module svt_cell (
    input  logic                    clk,
    input  svt_pkg::cell_ctrl_t     ctrl,
    input  logic [svt_pkg::IDX_W-1:0] index,
    input  svt_pkg::data_t          left_value,
    input  svt_pkg::data_t          right_value,
    input  svt_pkg::data_t          wrap_value,
    input  logic                    left_lt,
    input  logic                    left_swap,
    output svt_pkg::data_t          value,
    output logic                    lt,
    output logic                    eq,
    output logic                    swap
);

    svt_pkg::data_t                 value_reg;
    svt_pkg::data_t                 value_next;
    logic [svt_pkg::CNT_W-1:0]      pos;
    logic                           live;
    logic                           has_right;
    logic                           is_tail;
    logic                           order_wrong;

    // Locate this cell against the list length
    assign pos       = svt_pkg::CNT_W'(index);
    assign live      = pos < ctrl.count;
    assign has_right = (pos + svt_pkg::CNT_W'(1)) < ctrl.count;
    assign is_tail   = (pos + svt_pkg::CNT_W'(1)) == ctrl.count;

    // Compare against operand and right neighbor
    assign lt          = value_reg < ctrl.operand;
    assign eq          = value_reg == ctrl.operand;
    assign order_wrong = ctrl.descending ? (value_reg < right_value)
                                         : (right_value < value_reg);
    assign swap        = (ctrl.op == svt_pkg::OP_SORT) && (index[0] == ctrl.parity)
                         && has_right && order_wrong;
    assign value       = value_reg;

    // Pick the next entry value
    always_comb
    begin
        value_next = value_reg;
        unique case (ctrl.op)
            svt_pkg::OP_HOLD:
            begin
                value_next = value_reg;
            end
            svt_pkg::OP_APPEND:
            begin
                if (pos == ctrl.count)
                    value_next = ctrl.operand;
            end
            svt_pkg::OP_SORT:
            begin
                if (swap)
                    value_next = right_value;
                else if (left_swap)
                    value_next = left_value;
            end
            svt_pkg::OP_INSERT:
            begin
                if ((pos <= ctrl.count) && !(live && lt))
                    value_next = left_lt ? ctrl.operand : left_value;
            end
            svt_pkg::OP_DELETE:
            begin
                if (ctrl.any_match && live && !lt)
                    value_next = right_value;
            end
            svt_pkg::OP_ROT_FWD:
            begin
                if (live)
                    value_next = is_tail ? wrap_value : right_value;
            end
            svt_pkg::OP_ROT_BWD:
            begin
                if (live)
                    value_next = (index == '0) ? wrap_value : left_value;
            end
            default:
            begin
                value_next = value_reg;
            end
        endcase
    end

    // Hold the entry
    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

endmodule

// File: rtl/svt_checker.sv
// ----------------------------------------------------------------------------
// Sorted value table checker
// Watches the result port of the table core over time.
// ----------------------------------------------------------------------------
`include "sorted_value_table_core_assert.svh"

module svt_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               out_valid,
    input logic               out_stall,
    input svt_pkg::out_item_t out_item
);

    // Keep a stalled item in place
    `SVT_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid)
    `SVT_ASSERT_NEXT(a_out_stable, out_valid && out_stall, $stable(out_item))

    // Non-final items always point at an entry and carry no count
    `SVT_ASSERT_SAME(a_mid_pos, out_valid && !out_item.last, out_item.position != 6'd0)
    `SVT_ASSERT_SAME(a_mid_count, out_valid && !out_item.last, out_item.match_count == 6'd0)

    // Error status only ends a run
    `SVT_ASSERT_SAME(a_err_last, out_valid && (out_item.status != svt_pkg::ST_OK),
                     out_item.last)

endmodule

bind sorted_value_table_core svt_checker u_svt_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
);

// File: tb/tb_sorted_value_table_core.sv
// ----------------------------------------------------------------------------
// Sorted value table core testbench
// Drives list commands through a directed table and then random command
// mixes, predicts every result item from a behavioral copy of the list and
// compares each returned item field by field, in order.
// ----------------------------------------------------------------------------
module tb_sorted_value_table_core;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_ITEMS = 340;
    localparam int CYCLE_LIMIT  = 1000000;
    localparam int DRAIN_CYCLES = 80;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_stall;
    svt_pkg::in_item_t  in_item;
    logic               out_valid;
    logic               out_stall;
    svt_pkg::out_item_t out_item;

    sorted_value_table_core DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_item  (out_item)
    );

    // Behavioral copy of the list
    logic signed [31:0] list_vals [svt_pkg::CAPACITY];
    int                 list_len;
    svt_pkg::out_item_t pending_results [$];
    int                 error_count;
    int                 cycle_count;
    bit                 stim_done;

    // Directed stimulus row; has_exp marks rows with a typed-in result
    typedef struct {
        logic [3:0]  func;
        logic [31:0] value;
        bit          has_exp;
        logic [1:0]  exp_status;
    } stim_row_t;

    stim_row_t directed_rows [$];

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #10 clk = 1'b1;
            #10 clk = 1'b0;
        end
    end

    function automatic svt_pkg::out_item_t make_result(logic [31:0] val, int pos, int cnt,
                                                       logic [1:0] st, logic fin);
        svt_pkg::out_item_t r;
        r.item_value  = val;
        r.position    = pos[5:0];
        r.match_count = cnt[5:0];
        r.status      = st;
        r.last        = fin;
        return r;
    endfunction

    // Insertion sort on the copy, signed compare
    function automatic void order_list(bit descending);
        logic signed [31:0] v;
        int j;
        for (int i = 1; i < list_len; i++)
        begin
            v = list_vals[i];
            j = i;
            while (j > 0 && (descending ? (list_vals[j-1] < v) : (v < list_vals[j-1])))
            begin
                list_vals[j] = list_vals[j-1];
                j--;
            end
            list_vals[j] = v;
        end
    endfunction

    // Apply one command to the copy and queue the results it causes
    function automatic void predict_command(logic [3:0] func, logic signed [31:0] v);
        int i;
        int occ;
        int p;
        case (func)
            svt_pkg::FN_CLEAR:
            begin
                list_len = 0;
                pending_results.push_back(make_result(0, 0, 0, svt_pkg::ST_OK, 1'b1));
            end
            svt_pkg::FN_APPEND:
            begin
                if (v == 0)
                    pending_results.push_back(make_result(0, 0, 0, svt_pkg::ST_OK, 1'b1));
                else if (list_len >= svt_pkg::CAPACITY)
                    pending_results.push_back(make_result(0, 0, 0, svt_pkg::ST_FULL, 1'b1));
                else
                begin
                    list_vals[list_len] = v;
                    list_len++;
                    pending_results.push_back(make_result(0, 0, 0, svt_pkg::ST_OK, 1'b1));
                end
            end
            svt_pkg::FN_SORT_ASC, svt_pkg::FN_SORT_DESC:
            begin
                if (list_len == 0)
                    pending_results.push_back(make_result(0, 0, 0, svt_pkg::ST_EMPTY, 1'b1));
                else
                begin
                    order_list(func == svt_pkg::FN_SORT_DESC);
                    pending_results.push_back(make_result(0, 0, 0, svt_pkg::ST_OK, 1'b1));
                end
            end
            svt_pkg::FN_INSERT:
            begin
                if (list_len == 0)
                    pending_results.push_back(make_result(0, 0, 0, svt_pkg::ST_EMPTY, 1'b1));
                else
                begin
                    order_list(1'b0);
                    if (list_len >= svt_pkg::CAPACITY)
                        pending_results.push_back(
                            make_result(0, 0, 0, svt_pkg::ST_FULL, 1'b1));
                    else
                    begin
                        i = 0;
                        while (i < list_len && list_vals[i] < v)
                            i++;
                        for (int j = list_len; j > i; j--)
                            list_vals[j] = list_vals[j-1];
                        list_vals[i] = v;
                        list_len++;
                        pending_results.push_back(
                            make_result(0, 0, 0, svt_pkg::ST_OK, 1'b1));
                    end
                end
            end
            svt_pkg::FN_DELETE:
            begin
                if (list_len == 0)
                    pending_results.push_back(make_result(0, 0, 0, svt_pkg::ST_EMPTY, 1'b1));
                else
                begin
                    order_list(1'b0);
                    i = 0;
                    while (i < list_len && list_vals[i] != v)
                        i++;
                    if (i == list_len)
                        pending_results.push_back(
                            make_result(0, 0, 0, svt_pkg::ST_NOTFOUND, 1'b1));
                    else
                    begin
                        for (int j = i; j + 1 < list_len; j++)
                            list_vals[j] = list_vals[j+1];
                        list_len--;
                        pending_results.push_back(
                            make_result(0, 0, 0, svt_pkg::ST_OK, 1'b1));
                    end
                end
            end
            svt_pkg::FN_SEARCH:
            begin
                if (list_len == 0)
                    pending_results.push_back(make_result(0, 0, 0, svt_pkg::ST_EMPTY, 1'b1));
                else
                begin
                    occ = 0;
                    for (int j = 0; j < list_len; j++)
                        if (list_vals[j] == v)
                        begin
                            pending_results.push_back(
                                make_result(list_vals[j], j + 1, 0, svt_pkg::ST_OK, 1'b0));
                            occ++;
                        end
                    pending_results.push_back(make_result(0, 0, occ,
                        (occ != 0) ? svt_pkg::ST_OK : svt_pkg::ST_NOTFOUND, 1'b1));
                end
            end
            svt_pkg::FN_DUMP_FWD, svt_pkg::FN_DUMP_REV:
            begin
                if (list_len == 0)
                    pending_results.push_back(make_result(0, 0, 0, svt_pkg::ST_EMPTY, 1'b1));
                else
                    for (int j = 0; j < list_len; j++)
                    begin
                        p = (func == svt_pkg::FN_DUMP_FWD) ? j : list_len - 1 - j;
                        pending_results.push_back(make_result(list_vals[p], p + 1, 0,
                            svt_pkg::ST_OK, (j + 1 == list_len)));
                    end
            end
            default:
                pending_results.push_back(make_result(0, 0, 0, svt_pkg::ST_OK, 1'b1));
        endcase
    endfunction

    function automatic void add_row(logic [3:0] f, logic [31:0] v, bit he, logic [1:0] st);
        stim_row_t r;
        r.func       = f;
        r.value      = v;
        r.has_exp    = he;
        r.exp_status = st;
        directed_rows.push_back(r);
    endfunction

    // Values drawn mostly from a small pool so searches and deletes hit
    function automatic logic [31:0] pick_value();
        logic [31:0] pool [8] = '{32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'd1,
                                  32'd5, 32'hFFFF_FFFB, 32'd1000, 32'd0};
        case ($urandom_range(0, 3))
            0:       return $urandom();
            default: return pool[$urandom_range(0, 7)];
        endcase
    endfunction

    function automatic logic [3:0] pick_func();
        int r;
        r = $urandom_range(0, 99);
        if (r < 30)      return svt_pkg::FN_APPEND;
        else if (r < 42) return svt_pkg::FN_INSERT;
        else if (r < 54) return svt_pkg::FN_DELETE;
        else if (r < 68) return svt_pkg::FN_SEARCH;
        else if (r < 76) return svt_pkg::FN_DUMP_FWD;
        else if (r < 84) return svt_pkg::FN_DUMP_REV;
        else if (r < 89) return svt_pkg::FN_SORT_ASC;
        else if (r < 94) return svt_pkg::FN_SORT_DESC;
        else if (r < 97) return svt_pkg::FN_CLEAR;
        else             return 4'($urandom_range(9, 15));
    endfunction

    // Hand one item to the block, honoring bursts and gaps
    task automatic send_item(logic [3:0] f, logic [31:0] v);
        if ($urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        in_valid      <= 1'b1;
        in_item.func  <= f;
        in_item.value <= v;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        predict_command(f, v);
    endtask

    // Stimulus
    initial
    begin
        in_valid    = 1'b0;
        in_item     = '0;
        rst_n       = 1'b0;
        error_count = 0;
        list_len    = 0;
        stim_done   = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        add_row(svt_pkg::FN_DUMP_FWD,  32'd0,         1'b1, svt_pkg::ST_EMPTY);
        add_row(svt_pkg::FN_SEARCH,    32'd3,         1'b1, svt_pkg::ST_EMPTY);
        add_row(svt_pkg::FN_SORT_ASC,  32'd0,         1'b1, svt_pkg::ST_EMPTY);
        add_row(svt_pkg::FN_INSERT,    32'd4,         1'b1, svt_pkg::ST_EMPTY);
        add_row(svt_pkg::FN_DELETE,    32'd4,         1'b1, svt_pkg::ST_EMPTY);
        add_row(svt_pkg::FN_APPEND,    32'd0,         1'b1, svt_pkg::ST_OK);
        add_row(svt_pkg::FN_APPEND,    32'h7FFF_FFFF, 1'b1, svt_pkg::ST_OK);
        add_row(svt_pkg::FN_APPEND,    32'h8000_0000, 1'b1, svt_pkg::ST_OK);
        add_row(svt_pkg::FN_APPEND,    32'hFFFF_FFFF, 1'b1, svt_pkg::ST_OK);
        add_row(svt_pkg::FN_APPEND,    32'h5555_5555, 1'b1, svt_pkg::ST_OK);
        add_row(svt_pkg::FN_APPEND,    32'hAAAA_AAAA, 1'b1, svt_pkg::ST_OK);
        add_row(svt_pkg::FN_DUMP_REV,  32'd0,         1'b0, svt_pkg::ST_OK);
        add_row(svt_pkg::FN_SORT_DESC, 32'd0,         1'b1, svt_pkg::ST_OK);
        add_row(svt_pkg::FN_DUMP_FWD,  32'd0,         1'b0, svt_pkg::ST_OK);
        add_row(svt_pkg::FN_INSERT,    32'hFFFF_FFFF, 1'b1, svt_pkg::ST_OK);
        add_row(svt_pkg::FN_SEARCH,    32'hFFFF_FFFF, 1'b0, svt_pkg::ST_OK);
        add_row(svt_pkg::FN_SEARCH,    32'd12345,     1'b0, svt_pkg::ST_OK);
        add_row(svt_pkg::FN_DELETE,    32'd12345,     1'b1, svt_pkg::ST_NOTFOUND);
        add_row(svt_pkg::FN_DELETE,    32'h8000_0000, 1'b1, svt_pkg::ST_OK);
        add_row(4'd9,                  32'd7,         1'b1, svt_pkg::ST_OK);
        add_row(4'd15,                 32'd7,         1'b1, svt_pkg::ST_OK);
        add_row(svt_pkg::FN_DUMP_FWD,  32'd0,         1'b0, svt_pkg::ST_OK);
        add_row(svt_pkg::FN_CLEAR,     32'd0,         1'b1, svt_pkg::ST_OK);

        foreach (directed_rows[n])
        begin
            send_item(directed_rows[n].func, directed_rows[n].value);
            // Cross-check typed-in status against the predictor
            if (directed_rows[n].has_exp &&
                pending_results[pending_results.size()-1].status != directed_rows[n].exp_status)
            begin
                $error("row %0d status: expected %0d, predicted %0d", n,
                       directed_rows[n].exp_status,
                       pending_results[pending_results.size()-1].status);
                error_count++;
            end
        end

        // Fill to capacity and push past it
        for (int n = 0; n < svt_pkg::CAPACITY + 2; n++)
            send_item(svt_pkg::FN_APPEND, $urandom_range(1, 40));
        send_item(svt_pkg::FN_INSERT, 32'd7);
        send_item(svt_pkg::FN_SEARCH, 32'd7);
        send_item(svt_pkg::FN_DUMP_REV, 32'd0);
        send_item(svt_pkg::FN_CLEAR, 32'd0);

        // Random part
        for (int n = 0; n < RANDOM_ITEMS; n++)
            send_item(pick_func(), pick_value());
        in_valid  <= 1'b0;
        stim_done = 1'b1;
    end

    // Receiver stall pattern
    initial
    begin
        out_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            if ($urandom_range(0, 63) == 0)
            begin
                out_stall <= 1'b0;
                repeat ($urandom_range(20, 60)) @(posedge clk);
            end
            else
            begin
                case ($urandom_range(0, 7))
                    0, 1:    out_stall <= 1'b1;
                    default: out_stall <= 1'b0;
                endcase
            end
        end
    end

    // Compare each accepted result with the oldest expectation
    always @(posedge clk)
    begin
        svt_pkg::out_item_t exp_r;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_results.size() == 0)
            begin
                $error("unexpected result item: value %0d position %0d",
                       out_item.item_value, out_item.position);
                error_count++;
            end
            else
            begin
                exp_r = pending_results.pop_front();
                if (out_item.item_value !== exp_r.item_value)
                begin
                    $error("item_value: expected %0d, actual %0d",
                           exp_r.item_value, out_item.item_value);
                    error_count++;
                end
                if (out_item.position !== exp_r.position)
                begin
                    $error("position: expected %0d, actual %0d",
                           exp_r.position, out_item.position);
                    error_count++;
                end
                if (out_item.match_count !== exp_r.match_count)
                begin
                    $error("match_count: expected %0d, actual %0d",
                           exp_r.match_count, out_item.match_count);
                    error_count++;
                end
                if (out_item.status !== exp_r.status)
                begin
                    $error("status: expected %0d, actual %0d",
                           exp_r.status, out_item.status);
                    error_count++;
                end
                if (out_item.last !== exp_r.last)
                begin
                    $error("last: expected %0d, actual %0d", exp_r.last, out_item.last);
                    error_count++;
                end
            end
        end
    end

    // Drain, then report; the cycle counter bounds the run
    initial
    begin
        cycle_count = 0;
        while (!(stim_done && pending_results.size() == 0) && cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
        else
        begin
            repeat (DRAIN_CYCLES) @(posedge clk);
            if (error_count == 0 && pending_results.size() == 0)
                $display("No mismatches found");
            else
                $display("Mismatches found");
            $finish;
        end
    end

endmodule

// File: sim.f
+incdir+rtl
rtl/svt_pkg.sv
rtl/svt_cell.sv
rtl/sorted_value_table_core.sv
rtl/svt_checker.sv
tb/tb_sorted_value_table_core.sv
